// File: rtl/perfect_power_detector_defines.svh
// Assertion macros shared by the perfect power detector RTL.
`ifndef PERFECT_POWER_DETECTOR_DEFINES_SVH
`define PERFECT_POWER_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ppd_pkg.sv
// Package for the perfect power detector: defaults and sequencer states.
`default_nettype none

package ppd_pkg;

    // Default operand width
    localparam int DEF_VALUE_WIDTH = 64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_CHK,
        ST_DONE
    } ppd_state_t;

endpackage

`default_nettype wire

// File: rtl/ppd_mul.sv
// Shared half-width multiplier with registered product.
`default_nettype none

module ppd_mul #(
    parameter int OPW = (ppd_pkg::DEF_VALUE_WIDTH + 1) / 2
) (
    input  wire logic               clk,
    input  wire logic [OPW-1:0]     a,
    input  wire logic [OPW-1:0]     b,
    output logic      [2*OPW-1:0]   p_reg
);

    logic [2*OPW-1:0] p_next;

    // One partial product per cycle
    assign p_next = (2*OPW)'(a) * (2*OPW)'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

`default_nettype wire

// File: rtl/perfect_power_detector.sv
// Top level of the perfect power detector: sequencer and datapath.
`default_nettype none

`include "perfect_power_detector_defines.svh"

// Tests whether value equals b^e for integers b and e >= 2. An item is taken
// when start is high and busy is low. Busy then stays high through the cycle
// in which the single result appears on is_power with done high for exactly
// one cycle, and the result cannot be held off. Values 0 and 1 answer 0 in the
// cycle right after the item is taken.
// Otherwise the block walks exponents 2..VALUE_WIDTH and finds each root one
// bit at a time, MSB first, over ceil(VALUE_WIDTH/2) candidate bits. Each
// candidate takes a setup step, then per multiplication a low-half, high-half,
// accumulate and compare step, and its powering stops at the first product
// above the value; a match ends the item at once. The one half-width
// multiplier is reused for every partial product.
module perfect_power_detector #(
    parameter int VALUE_WIDTH = ppd_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        busy,
    output logic                        done,
    output logic                        is_power
);

    localparam int BW  = (VALUE_WIDTH + 1) / 2;     // root width
    localparam int PW  = VALUE_WIDTH + BW;          // full product width
    localparam int EW  = $clog2(VALUE_WIDTH + 1);   // exponent counter width
    localparam int BIW = $clog2(BW);                // root bit index width

    ppd_pkg::ppd_state_t state_reg, state_next;

    logic [EW-1:0]          e_reg, e_next;
    logic [EW-1:0]          cnt_reg, cnt_next;
    logic [BIW-1:0]         bit_reg, bit_next;
    logic                   found_reg, found_next;
    logic [VALUE_WIDTH-1:0] m_reg, m_next;
    logic [VALUE_WIDTH-1:0] prod_reg, prod_next;
    logic [BW-1:0]          root_reg, root_next;
    logic [BW-1:0]          cand_reg, cand_next;
    logic [2*BW-1:0]        plo_reg, plo_next;
    logic [PW-1:0]          sum_reg, sum_next;

    logic [BW-1:0]          mul_a;
    logic [2*BW-1:0]        mul_p;

    logic over, last_mul, hit, advance, end_search, small_in;

    // Shared multiplier: low half of the running product, then the high half
    assign mul_a = (state_reg == ppd_pkg::ST_MUL_HI) ?
                   BW'(prod_reg[VALUE_WIDTH-1:BW]) : prod_reg[BW-1:0];

    ppd_mul #(
        .OPW (BW)
    ) u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (cand_reg),
        .p_reg (mul_p)
    );

    // Compare results of the current multiplication step
    assign small_in   = value < VALUE_WIDTH'(2);
    assign over       = sum_reg > PW'(m_reg);
    assign last_mul   = (cnt_reg + EW'(1)) == e_reg;
    assign hit        = !over && last_mul && (sum_reg == PW'(m_reg));
    assign advance    = over || (last_mul && !hit);
    assign end_search = advance && (bit_reg == '0) && (e_reg == EW'(VALUE_WIDTH));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppd_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = small_in ? ppd_pkg::ST_DONE : ppd_pkg::ST_CAND;
            end
            ppd_pkg::ST_CAND:   state_next = ppd_pkg::ST_MUL_LO;
            ppd_pkg::ST_MUL_LO: state_next = ppd_pkg::ST_MUL_HI;
            ppd_pkg::ST_MUL_HI: state_next = ppd_pkg::ST_ACC;
            ppd_pkg::ST_ACC:    state_next = ppd_pkg::ST_CHK;
            ppd_pkg::ST_CHK:
            begin
                if (hit || end_search)
                    state_next = ppd_pkg::ST_DONE;
                else if (advance)
                    state_next = ppd_pkg::ST_CAND;
                else
                    state_next = ppd_pkg::ST_MUL_LO;
            end
            ppd_pkg::ST_DONE:   state_next = ppd_pkg::ST_IDLE;
            default:            state_next = ppd_pkg::ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        e_next     = e_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        found_next = found_reg;
        m_next     = m_reg;
        prod_next  = prod_reg;
        root_next  = root_reg;
        cand_next  = cand_reg;
        plo_next   = plo_reg;
        sum_next   = sum_reg;
        case (state_reg)
            ppd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    m_next     = value;
                    e_next     = EW'(2);
                    bit_next   = BIW'(BW - 1);
                    root_next  = '0;
                    found_next = 1'b0;
                end
            end
            ppd_pkg::ST_CAND:
            begin
                cand_next = root_reg | (BW'(1) << bit_reg);
                prod_next = VALUE_WIDTH'(1);
                cnt_next  = '0;
            end
            ppd_pkg::ST_MUL_HI:
            begin
                plo_next = mul_p;
            end
            ppd_pkg::ST_ACC:
            begin
                sum_next = PW'({mul_p, {BW{1'b0}}}) + PW'(plo_reg);
            end
            ppd_pkg::ST_CHK:
            begin
                if (!over)
                begin
                    prod_next = sum_reg[VALUE_WIDTH-1:0];
                    cnt_next  = cnt_reg + EW'(1);
                end
                if (hit)
                    found_next = 1'b1;
                if (advance && !end_search)
                begin
                    if (!over)
                        root_next = cand_reg;
                    if (bit_reg == '0)
                    begin
                        e_next    = e_reg + EW'(1);
                        bit_next  = BIW'(BW - 1);
                        root_next = '0;
                    end
                    else
                    begin
                        bit_next = bit_reg - BIW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppd_pkg::ST_IDLE;
            e_reg     <= '0;
            cnt_reg   <= '0;
            bit_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            cnt_reg   <= cnt_next;
            bit_reg   <= bit_next;
            found_reg <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        prod_reg <= prod_next;
        root_reg <= root_next;
        cand_reg <= cand_next;
        plo_reg  <= plo_next;
        sum_reg  <= sum_next;
    end

    // Outputs
    always_comb
    begin
        busy     = state_reg != ppd_pkg::ST_IDLE;
        done     = state_reg == ppd_pkg::ST_DONE;
        is_power = found_reg;
    end

    // Checks
    `PPD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "item accepted but not busy")
    `PPD_ASSERT_NXT(a_done_idle, clk, rst_n, done, !busy && !done, "result not followed by idle")
    `PPD_ASSERT_IMP(a_small_false, clk, rst_n, done && is_power, m_reg >= VALUE_WIDTH'(2), "0 or 1 reported as power")

endmodule

`default_nettype wire

// File: dv/tb_perfect_power_detector.sv
// Self-checking testbench for the perfect power detector: directed and random values.
`default_nettype none

module tb_perfect_power_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW             = ppd_pkg::DEF_VALUE_WIDTH;
    localparam int RANDOM_ITEMS   = 116;
    localparam int PHASE_COUNT    = 4;
    // Watchdog limit, set well above the longest item
    localparam int STALL_LIMIT    = 2_000_000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum int {
        IDLE_NONE,
        IDLE_HEAVY,
        IDLE_LIGHT
    } idle_mode_t;

    // Expected answers for accepted items, oldest first
    class ppd_scoreboard;
        bit answers_due[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Compare base^exp with target without overflow: -1, 0 or 1
        function automatic int power_order(bit [63:0] base, int exp, bit [63:0] target);
            bit [63:0] prod;
            prod = 64'd1;
            for (int i = 0; i < exp; i++)
            begin
                if (prod > target / base)
                    return 1;
                prod = prod * base;
            end
            if (prod == target)
                return 0;
            return (prod < target) ? -1 : 1;
        endfunction

        // Binary search for an integer root at each exponent up to the bit length
        function automatic bit perfect_power(bit [VW-1:0] val);
            bit [63:0] m;
            bit [63:0] lo;
            bit [63:0] hi;
            bit [63:0] mid;
            int nbits;
            int order;
            m = 64'(val);
            nbits = 0;
            for (int i = 0; i < 64; i++)
                if (m[i])
                    nbits = i + 1;
            if (m < 64'd2)
                return 1'b0;
            for (int e = 2; e <= nbits; e++)
            begin
                lo = 64'd1;
                hi = m;
                while (lo <= hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    order = power_order(mid, e, m);
                    if (order == 0)
                        return 1'b1;
                    if (order < 0)
                        lo = mid + 1;
                    else
                    begin
                        if (mid <= 64'd1)
                            break;
                        hi = mid - 1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_value(bit [VW-1:0] val);
            answers_due.push_back(perfect_power(val));
        endfunction

        function void check_result(logic actual);
            bit want;
            if (answers_due.size() == 0)
            begin
                $error("is_power: no item pending, actual %0d", actual);
                errors++;
                return;
            end
            want = answers_due.pop_front();
            if (actual !== want)
            begin
                $error("is_power: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic [VW-1:0] value;
    logic          busy;
    logic          done;
    logic          is_power;

    ppd_scoreboard sb = new();
    idle_mode_t    idle_mode;
    int            stall_count;

    perfect_power_detector #(.VALUE_WIDTH(VW)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .busy     (busy),
        .done     (done),
        .is_power (is_power)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Monitor: results first, then accepted items; watchdog on lack of progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(is_power);
            if (start && !busy)
                sb.note_value(value);
        end
        if (!rst_n || done || (start && !busy))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit [63:0] int_pow(bit [63:0] base, int exp);
        bit [63:0] prod;
        prod = 64'd1;
        for (int i = 0; i < exp; i++)
            prod = prod * base;
        return prod;
    endfunction

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random perfect power that fits in 64 bits
    function automatic bit [63:0] rand_power();
        int exp;
        int base_bits;
        bit [63:0] base;
        exp = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 63) : $urandom_range(2, 6);
        base_bits = 64 / exp;
        base = rand64() & ((64'd1 << base_bits) - 64'd1);
        if (base < 64'd2)
            base = 64'd2;
        return int_pow(base, exp);
    endfunction

    // Mostly perfect powers and near misses, plus noise of varied bit length
    function automatic bit [63:0] rand_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return rand_power();
        else if (pick < 60)
            return ($urandom_range(0, 1) == 1) ? rand_power() + 64'd1 : rand_power() - 64'd1;
        else if (pick < 70)
            return 64'($urandom_range(0, 1000));
        else if (pick < 90)
            return rand64() >> $urandom_range(0, 63);
        return rand64();
    endfunction

    // Sender gap according to the current idle mode
    function automatic int idle_gap();
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_HEAVY) ? 84 : (idle_mode == IDLE_LIGHT) ? 25 : 0;
        while (gap < 30 && $urandom_range(0, 99) < pct)
            gap++;
        return gap;
    endfunction

    // Present one item and hold it until accepted
    task automatic send_value(input bit [VW-1:0] val);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= val;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending until every pending answer has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit [63:0] directed[$];
        rst_n     = 1'b0;
        start     = 1'b0;
        value     = '0;
        idle_mode = IDLE_NONE;
        stall_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero and one, small powers, extremes and near misses
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9,
                     {64{1'b1}}, {64{1'b1}} - 64'd1,
                     64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                     64'h8000_0000_0000_0001, 64'h4000_0000_0000_0000,
                     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'h0000_0001_0000_0000};
        directed.push_back(int_pow(64'hFFFF_FFFF, 2));
        directed.push_back(int_pow(64'hFFFF_FFFF, 2) + 64'd1);
        directed.push_back(int_pow(64'hFFFF_FFFF, 2) - 64'd1);
        directed.push_back(int_pow(64'd3, 40));
        directed.push_back(int_pow(64'd3, 40) - 64'd1);
        directed.push_back(int_pow(64'd7, 22));
        directed.push_back(int_pow(64'd10, 19));
        directed.push_back(int_pow(64'd2642245, 3));
        foreach (directed[i])
            send_value(directed[i][VW-1:0]);
        drain_results();

        // Random phases with different sender idling, draining in between
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1: idle_mode = IDLE_HEAVY;
                2: idle_mode = IDLE_LIGHT;
                default: idle_mode = IDLE_NONE;
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++)
                send_value(rand_value());
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("is_power: %0d expected results never came", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
